// ----- rtl/fcbh_pkg.sv -----
`default_nettype none
package fcbh_pkg;

  typedef enum logic [2:0] {
    CMD_FREE       = 3'd0,
    CMD_NOMINATE   = 3'd1,
    CMD_CHECK      = 3'd2,
    CMD_RESEED_CLR = 3'd3,
    CMD_RESEED_MRK = 3'd4,
    CMD_INVALIDATE = 3'd5,
    CMD_RSVD6      = 3'd6,
    CMD_RSVD7      = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] pool_tag;
    logic [15:0] chunk_index;
    logic [15:0] chunk_count;
    logic        head_present;
    logic        next_present;
  } in_item_t;

  typedef struct packed {
    logic        nominated;
    logic [11:0] found_index;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_CLEAR,
    OP_CLAIM_SET,
    OP_CLAIM,
    OP_SCAN
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] index;
    logic [16:0] count;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIPE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CLEAN_WR,
    ST_DONE
  } bst_e;

endpackage
`default_nettype wire

// ----- rtl/fcbh_front.sv -----
`default_nettype none
module fcbh_front #(
  parameter int MAX_CHUNKS = 4096,
  parameter int POOL_SLOTS = 8,
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              enabled_i,
  input  wire logic              push_i,
  input  wire fcbh_pkg::in_item_t item_i,
  output logic                   full_o,
  output logic                   wr_o,
  output fcbh_pkg::work_t        work_o,
  output logic [SW-1:0]          slot_o,
  input  wire logic              q_full_i
);
  logic [31:0] owner_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] valid_q;
  logic [SW-1:0] s;
  logic owned, idx_ok, acc;
  fcbh_pkg::op_e op;

  assign s = (POOL_SLOTS > 1) ? SW'((item_i.pool_tag >> 4) % POOL_SLOTS) : '0;
  assign owned = valid_q[s] && owner_q[s] == item_i.pool_tag;
  assign idx_ok = 32'(item_i.chunk_index) < MAX_CHUNKS;
  assign full_o = q_full_i;
  assign acc = push_i && !q_full_i;

  always_comb begin
    op = fcbh_pkg::OP_NONE;
    case (fcbh_pkg::cmd_e'(item_i.command))
      fcbh_pkg::CMD_FREE:
        if (enabled_i && idx_ok) op = owned ? fcbh_pkg::OP_SET : fcbh_pkg::OP_CLAIM_SET;
      fcbh_pkg::CMD_NOMINATE:
        if (enabled_i && owned && item_i.chunk_count != 0) op = fcbh_pkg::OP_SCAN;
      fcbh_pkg::CMD_CHECK:
        if (owned && idx_ok && (!item_i.head_present || !item_i.next_present))
          op = fcbh_pkg::OP_CLEAR;
      fcbh_pkg::CMD_RESEED_CLR: op = fcbh_pkg::OP_CLAIM;
      fcbh_pkg::CMD_RESEED_MRK: if (owned && idx_ok) op = fcbh_pkg::OP_SET;
      default: op = fcbh_pkg::OP_NONE;
    endcase
  end

  assign wr_o = acc;
  assign work_o = '{op: op, index: item_i.chunk_index,
                    count: {1'b0, item_i.chunk_count}};
  assign slot_o = s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (acc) begin
      if (item_i.command == fcbh_pkg::CMD_INVALIDATE) valid_q[s] <= 1'b0;
      else if (op == fcbh_pkg::OP_CLAIM || op == fcbh_pkg::OP_CLAIM_SET) valid_q[s] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (item_i.command == fcbh_pkg::CMD_INVALIDATE) owner_q[s] <= '0;
      else if (op == fcbh_pkg::OP_CLAIM || op == fcbh_pkg::OP_CLAIM_SET)
        owner_q[s] <= item_i.pool_tag;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/fcbh_queue.sv -----
`default_nettype none
module fcbh_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              full_o,
  input  wire logic         rd_i,
  output logic [W-1:0]      rdata_o,
  output logic              empty_o
);
  logic [W-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end
endmodule
`default_nettype wire

// ----- rtl/fcbh_back.sv -----
`default_nettype none
module fcbh_back #(
  parameter int MAX_CHUNKS = 4096,
  parameter int POOL_SLOTS = 8,
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  localparam int NW = (MAX_CHUNKS + 31) / 32,
  localparam int WW = (NW > 1) ? $clog2(NW) : 1,
  localparam int AW = SW + WW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire fcbh_pkg::work_t   work_i,
  input  wire logic [SW-1:0]     slot_i,
  output logic                   q_rd_o,
  output logic                   res_valid_o,
  output fcbh_pkg::out_item_t    res_o,
  input  wire logic              res_take_i
);
  logic [31:0] mem_q [POOL_SLOTS*NW];
  logic [31:0] rdata_q;
  fcbh_pkg::bst_e st_q, st_d;
  logic [WW:0] w_q, w_d, lim_q, lim_d;
  logic [AW-1:0] raddr, waddr;
  logic re, we;
  logic [31:0] wdata, inmask, lowmask;
  logic [4:0] fb;
  logic any;
  logic hit_q, hit_d;
  logic [11:0] fidx_q, fidx_d;
  logic [16:0] base;
  logic [WW-1:0] wi;
  logic clean_ph_q;

  assign wi = w_q[WW-1:0];
  assign raddr = AW'(slot_i) * AW'(NW) + AW'(wi);
  assign waddr = raddr;
  assign base = 17'({w_q, 5'd0});

  always_comb begin
    for (int b = 0; b < 32; b++) inmask[b] = (17'(base) + 17'(b)) < work_i.count;
    lowmask = rdata_q & inmask;
    any = |lowmask;
    fb = '0;
    for (int b = 31; b >= 0; b--) if (lowmask[b]) fb = 5'(b);
  end

  always_comb begin
    st_d = st_q;
    w_d = w_q;
    lim_d = lim_q;
    hit_d = hit_q;
    fidx_d = fidx_q;
    re = 1'b0;
    we = 1'b0;
    wdata = '0;
    q_rd_o = 1'b0;
    unique case (st_q)
      fcbh_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          hit_d = 1'b0;
          fidx_d = '0;
          w_d = '0;
          unique case (work_i.op)
            fcbh_pkg::OP_SET, fcbh_pkg::OP_CLEAR: begin
              w_d = (WW+1)'(work_i.index >> 5);
              st_d = fcbh_pkg::ST_RMW_RD;
            end
            fcbh_pkg::OP_CLAIM, fcbh_pkg::OP_CLAIM_SET: st_d = fcbh_pkg::ST_WIPE;
            fcbh_pkg::OP_SCAN: begin
              lim_d = (work_i.count + 17'd31) >> 5 > 17'(NW) ? (WW+1)'(NW)
                    : (WW+1)'((work_i.count + 17'd31) >> 5);
              st_d = fcbh_pkg::ST_SCAN_RD;
            end
            default: st_d = fcbh_pkg::ST_DONE;
          endcase
        end
      end
      fcbh_pkg::ST_WIPE: begin
        we = 1'b1;
        w_d = w_q + 1'b1;
        if (w_q == (WW+1)'(NW - 1)) begin
          if (work_i.op == fcbh_pkg::OP_CLAIM_SET) begin
            w_d = (WW+1)'(work_i.index >> 5);
            st_d = fcbh_pkg::ST_RMW_RD;
          end else st_d = fcbh_pkg::ST_DONE;
        end
      end
      fcbh_pkg::ST_RMW_RD: begin
        re = 1'b1;
        st_d = fcbh_pkg::ST_RMW_WR;
      end
      fcbh_pkg::ST_RMW_WR: begin
        we = 1'b1;
        wdata = (work_i.op == fcbh_pkg::OP_CLEAR)
              ? rdata_q & ~(32'd1 << work_i.index[4:0])
              : rdata_q | (32'd1 << work_i.index[4:0]);
        st_d = fcbh_pkg::ST_DONE;
      end
      fcbh_pkg::ST_SCAN_RD: begin
        if (w_q == lim_q) begin
          w_d = '0;
          st_d = fcbh_pkg::ST_CLEAN_WR;
        end else begin
          re = 1'b1;
          st_d = fcbh_pkg::ST_SCAN_CHK;
        end
      end
      fcbh_pkg::ST_SCAN_CHK: begin
        if (any) begin
          hit_d = 1'b1;
          fidx_d = 12'({w_q, fb});
          st_d = fcbh_pkg::ST_DONE;
        end else begin
          w_d = w_q + 1'b1;
          st_d = fcbh_pkg::ST_SCAN_RD;
        end
      end
      fcbh_pkg::ST_CLEAN_WR: begin
        if (w_q == lim_q) st_d = fcbh_pkg::ST_DONE;
        else if (!clean_ph_q) re = 1'b1;
        else begin
          we = 1'b1;
          wdata = rdata_q & inmask;
          w_d = w_q + 1'b1;
        end
      end
      fcbh_pkg::ST_DONE: begin
        if (!res_valid_o || res_take_i) begin
          q_rd_o = 1'b1;
          st_d = fcbh_pkg::ST_IDLE;
        end
      end
      default: st_d = fcbh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= fcbh_pkg::ST_IDLE;
      clean_ph_q <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      clean_ph_q <= (st_q == fcbh_pkg::ST_CLEAN_WR) && !clean_ph_q && w_q != lim_q;
      if (q_rd_o) res_valid_o <= 1'b1;
      else if (res_take_i) res_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    lim_q <= lim_d;
    hit_q <= hit_d;
    fidx_q <= fidx_d;
    if (q_rd_o) res_o <= '{nominated: hit_q, found_index: fidx_q};
    if (re) rdata_q <= mem_q[raddr];
    if (we) mem_q[waddr] <= wdata;
  end
endmodule
`default_nettype wire

// ----- rtl/free_chunk_bitmap_hint.sv -----
// Free-chunk bitmap hint: slot owners are checked and items classified at the input, then a
// 2-entry queue feeds a sequencer on a single-port bitmap memory with one read or one write
// a cycle, which sets the time for an item. Bitmap memory is not cleared by reset; a claim
// wipes a slot before it is used, and slot owners are reset. The sequencer does a set or
// clear as a read and then a write of one word; a reseed clear wipes all NW words of the slot
// (NW = MAX_CHUNKS/32 rounded up, 128 by default), and a free that claims its slot wipes it
// and then sets the bit. A nominate reads words until one holds a set bit in range; on a
// miss it reads and writes back each scanned word masked to the range. One result is
// produced per item; while it waits unread the sequencer holds, the queue fills and full rises.
`default_nettype none
module free_chunk_bitmap_hint #(
  parameter int MAX_CHUNKS = 4096,
  parameter int POOL_SLOTS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire fcbh_pkg::in_item_t  item_i,
  output logic                     empty,
  input  wire logic                pop,
  output fcbh_pkg::out_item_t      item_o
);
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int QW = $bits(fcbh_pkg::work_t) + SW;

  logic enabled_q, wr, qfull, qempty, qrd, rv;
  fcbh_pkg::work_t fw, bw;
  logic [SW-1:0] fs, bs;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) enabled_q <= 1'b0;
    else if (cfg_valid_i) enabled_q <= cfg_data_i;
  end

  fcbh_front #(.MAX_CHUNKS(MAX_CHUNKS), .POOL_SLOTS(POOL_SLOTS)) u_front (
    .clk_i, .rst_ni, .enabled_i(enabled_q), .push_i(push), .item_i,
    .full_o(full), .wr_o(wr), .work_o(fw), .slot_o(fs), .q_full_i(qfull));

  fcbh_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni, .wr_i(wr), .wdata_i({fw, fs}), .full_o(qfull),
    .rd_i(qrd), .rdata_o({bw, bs}), .empty_o(qempty));

  fcbh_back #(.MAX_CHUNKS(MAX_CHUNKS), .POOL_SLOTS(POOL_SLOTS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(qempty), .work_i(bw), .slot_i(bs),
    .q_rd_o(qrd), .res_valid_o(rv), .res_o(item_o), .res_take_i(pop && !empty));

  assign empty = !rv;

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qfull |-> !wr) else $error("queue overflow");
  a_no_udf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qrd |-> !qempty) else $error("queue underflow");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv && !pop) |=> rv) else $error("result dropped");
endmodule
`default_nettype wire
